// ===== hw/rtl/bba_pkg.sv =====
// Shared types and codes for the block bitmap allocator.
// Holds op, status and register index codes plus the controller/datapath structs.
package bba_pkg;

   localparam int OP_W      = 3;
   localparam int BLK_W     = 16;
   localparam int CFG_W     = 17;
   localparam int STAT_W    = 2;
   localparam int FC_W      = 17;
   localparam int CSR_IDX_W = 1;

   localparam logic [OP_W-1:0] OP_ALLOC = 3'd0;
   localparam logic [OP_W-1:0] OP_FREE  = 3'd1;
   localparam logic [OP_W-1:0] OP_MARK  = 3'd2;
   localparam logic [OP_W-1:0] OP_TEST  = 3'd3;
   localparam logic [OP_W-1:0] OP_INIT  = 3'd4;

   localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
   localparam logic [STAT_W-1:0] ST_NOFREE  = 2'd1;
   localparam logic [STAT_W-1:0] ST_RANGE   = 2'd2;
   localparam logic [STAT_W-1:0] ST_DBLFREE = 2'd3;

   localparam logic [CSR_IDX_W-1:0] CSR_TOTAL = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_RESV  = 1'd1;

   localparam logic [CFG_W-1:0] TOTAL_RST = 17'd65536;
   localparam logic [CFG_W-1:0] RESV_RST  = 17'd0;

   typedef struct packed {
      logic accept;
      logic clear;
      logic scan;
      logic alloc_hit;
      logic alloc_fail;
      logic walk;
      logic bitop;
   } cmd_type;

   typedef struct packed {
      logic in_range;
      logic clr_last;
      logic issue_ok;
      logic chk_vld;
      logic chk_hit;
      logic chk_miss;
      logic walk_hit;
   } status_type;

endpackage

// ===== hw/rtl/bba_dpath.sv =====
// Datapath of the block bitmap allocator: map memory, scan pointers, counters.
// Depends on bba_pkg; driven by bba_ctrl through cmd_type, reports status_type.
module bba_dpath #(
   parameter int MAX_BLOCKS = 65536,
   parameter int WORD_BITS  = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   input  bba_pkg::cmd_type              cmd,
   output bba_pkg::status_type           stat,
   input  logic [bba_pkg::OP_W-1:0]      req_op,
   input  logic [bba_pkg::BLK_W-1:0]     req_block_index,
   input  logic                          csr_we,
   input  logic [bba_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [bba_pkg::CFG_W-1:0]     csr_wdata,
   output logic [bba_pkg::BLK_W-1:0]     rsp_result_block,
   output logic                          rsp_bit_value,
   output logic [bba_pkg::STAT_W-1:0]    rsp_status,
   output logic [bba_pkg::FC_W-1:0]      rsp_free_count
);

   localparam int MAP_WORDS = (MAX_BLOCKS + WORD_BITS - 1) / WORD_BITS;
   localparam int AW        = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
   localparam int PW        = $clog2(WORD_BITS);
   localparam int CW        = $clog2(MAX_BLOCKS + 1);
   localparam int EW0       = $clog2(MAP_WORDS * WORD_BITS + 1);
   localparam int EW        = (EW0 > bba_pkg::CFG_W) ? EW0 : bba_pkg::CFG_W;

   localparam logic [EW-1:0]        WB_E    = EW'(WORD_BITS);
   localparam logic [EW-1:0]        MAX_E   = EW'(MAX_BLOCKS);
   localparam logic [AW:0]          WORDS_E = (AW+1)'(MAP_WORDS);
   localparam logic [AW:0]          LAST_E  = (AW+1)'(MAP_WORDS - 1);
   localparam logic [PW:0]          WB_N    = (PW+1)'(WORD_BITS);
   localparam logic [PW-1:0]        TOP_BIT = PW'(WORD_BITS - 1);
   localparam logic [WORD_BITS-1:0] ONES    = {WORD_BITS{1'b1}};
   localparam logic [WORD_BITS-1:0] ONE     = WORD_BITS'(1);

   logic [WORD_BITS-1:0] mem [MAP_WORDS];

   logic [bba_pkg::CFG_W-1:0]  total_ff, total_in, resv_ff, resv_in;
   logic [CW-1:0]              free_ff, free_in;
   logic [EW-1:0]              lim_ff, lim_in;
   logic [AW:0]                word_ff, word_in;
   logic [EW-1:0]              base_ff, base_in;
   logic                       rd_vld_ff, rd_vld_in;
   logic [bba_pkg::OP_W-1:0]   op_ff, op_in;
   logic [bba_pkg::BLK_W-1:0]  idx_ff, idx_in;
   logic [bba_pkg::BLK_W-1:0]  res_blk_ff, res_blk_in;
   logic                       bitv_ff, bitv_in;
   logic [bba_pkg::STAT_W-1:0] stat_ff, stat_in;
   logic [WORD_BITS-1:0]       rd_data_ff;
   logic [AW-1:0]              rd_word_ff;
   logic [EW-1:0]              rd_base_ff;

   logic [EW-1:0]        eff, resv_eff, base_next, lim_diff, chk_blk, idx_rel;
   logic [EW:0]          walk_end;
   logic [PW:0]          fill_n;
   logic [WORD_BITS-1:0] fill_word, bit_mask, zero_mask;
   logic                 zfound, cur_used, free_dec_ok, free_inc_ok;
   logic [PW-1:0]        zpos, zbit, off, bpos;
   logic                 mem_we;
   logic [AW-1:0]        mem_waddr;
   logic [WORD_BITS-1:0] mem_wdata;

   // Effective size, reserve clamp and fill word for the clearing pass
   always_comb begin
      eff       = (EW'(total_ff) > MAX_E) ? MAX_E : EW'(total_ff);
      resv_eff  = (EW'(resv_ff) > eff) ? eff : EW'(resv_ff);
      base_next = base_ff + WB_E;
      lim_diff  = lim_ff - base_ff;
      if (lim_ff <= base_ff) begin
         fill_n = '0;
      end else if (lim_diff >= WB_E) begin
         fill_n = WB_N;
      end else begin
         fill_n = (PW+1)'(lim_diff);
      end
      fill_word = ~(ONES >> fill_n);
   end

   // First free bit, most significant first
   always_comb begin
      zfound = 1'b0;
      zpos   = '0;
      zbit   = '0;
      for (int i = 0; i < WORD_BITS; i++) begin
         if (!zfound && !rd_data_ff[WORD_BITS-1-i]) begin
            zfound = 1'b1;
            zpos   = PW'(i);
            zbit   = PW'(WORD_BITS - 1 - i);
         end
      end
      chk_blk   = rd_base_ff + EW'(zpos);
      zero_mask = ONE << zbit;
   end

   always_comb begin
      walk_end    = {1'b0, base_ff} + (EW+1)'(WORD_BITS);
      idx_rel     = EW'(idx_ff) - base_ff;
      off         = PW'(idx_rel);
      bpos        = TOP_BIT - off;
      bit_mask    = ONE << bpos;
      cur_used    = rd_data_ff[bpos];
      free_dec_ok = (free_ff != '0);
      free_inc_ok = (EW'(free_ff) < eff);
   end

   always_comb begin
      stat.in_range = (EW'(req_block_index) < eff);
      stat.clr_last = (word_ff == LAST_E);
      stat.issue_ok = (word_ff < WORDS_E) && (base_ff < eff);
      stat.chk_vld  = rd_vld_ff;
      stat.chk_hit  = rd_vld_ff && zfound && (chk_blk < eff);
      stat.chk_miss = rd_vld_ff && zfound && !(chk_blk < eff);
      stat.walk_hit = ((EW+1)'(idx_ff) < walk_end);
   end

   // Map write port
   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = rd_word_ff;
      mem_wdata = rd_data_ff;
      if (cmd.clear) begin
         mem_we    = 1'b1;
         mem_waddr = word_ff[AW-1:0];
         mem_wdata = fill_word;
      end else if (cmd.alloc_hit) begin
         mem_we    = 1'b1;
         mem_wdata = rd_data_ff | zero_mask;
      end else if (cmd.bitop) begin
         if (op_ff == bba_pkg::OP_FREE && cur_used) begin
            mem_we    = 1'b1;
            mem_wdata = rd_data_ff & ~bit_mask;
         end else if (op_ff == bba_pkg::OP_MARK && !cur_used) begin
            mem_we    = 1'b1;
            mem_wdata = rd_data_ff | bit_mask;
         end
      end
   end

   always_comb begin
      total_in   = total_ff;
      resv_in    = resv_ff;
      free_in    = free_ff;
      lim_in     = lim_ff;
      word_in    = word_ff;
      base_in    = base_ff;
      rd_vld_in  = cmd.scan && stat.issue_ok;
      op_in      = op_ff;
      idx_in     = idx_ff;
      res_blk_in = res_blk_ff;
      bitv_in    = bitv_ff;
      stat_in    = stat_ff;

      if (csr_we) begin
         case (csr_index)
            bba_pkg::CSR_TOTAL: total_in = csr_wdata;
            bba_pkg::CSR_RESV:  resv_in  = csr_wdata;
            default:            total_in = total_ff;
         endcase
      end

      if (cmd.accept) begin
         op_in      = req_op;
         idx_in     = req_block_index;
         word_in    = '0;
         base_in    = '0;
         res_blk_in = req_block_index;
         bitv_in    = 1'b0;
         stat_in    = bba_pkg::ST_OK;
         case (req_op)
            bba_pkg::OP_ALLOC: begin
               res_blk_in = '0;
            end
            bba_pkg::OP_FREE, bba_pkg::OP_MARK, bba_pkg::OP_TEST: begin
               if (!stat.in_range) begin
                  stat_in = bba_pkg::ST_RANGE;
               end
            end
            bba_pkg::OP_INIT: begin
               res_blk_in = '0;
               free_in    = CW'(eff - resv_eff);
               lim_in     = resv_eff;
            end
            default: begin
               res_blk_in = req_block_index;
            end
         endcase
      end

      if (cmd.clear || (cmd.scan && stat.issue_ok) || (cmd.walk && !stat.walk_hit)) begin
         word_in = word_ff + 1'b1;
         base_in = base_next;
      end

      if (cmd.alloc_hit) begin
         res_blk_in = bba_pkg::BLK_W'(chk_blk);
         if (free_dec_ok) begin
            free_in = free_ff - 1'b1;
         end
      end

      if (cmd.alloc_fail) begin
         stat_in = bba_pkg::ST_NOFREE;
      end

      if (cmd.bitop) begin
         bitv_in = cur_used;
         case (op_ff)
            bba_pkg::OP_FREE: begin
               if (!cur_used) begin
                  stat_in = bba_pkg::ST_DBLFREE;
               end else if (free_inc_ok) begin
                  free_in = free_ff + 1'b1;
               end
            end
            bba_pkg::OP_MARK: begin
               if (!cur_used && free_dec_ok) begin
                  free_in = free_ff - 1'b1;
               end
            end
            default: begin
               stat_in = stat_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff  <= bba_pkg::TOTAL_RST;
         resv_ff   <= bba_pkg::RESV_RST;
         free_ff   <= CW'(MAX_BLOCKS);
         lim_ff    <= '0;
         word_ff   <= '0;
         base_ff   <= '0;
         rd_vld_ff <= 1'b0;
      end else begin
         total_ff  <= total_in;
         resv_ff   <= resv_in;
         free_ff   <= free_in;
         lim_ff    <= lim_in;
         word_ff   <= word_in;
         base_ff   <= base_in;
         rd_vld_ff <= rd_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff      <= op_in;
      idx_ff     <= idx_in;
      res_blk_ff <= res_blk_in;
      bitv_ff    <= bitv_in;
      stat_ff    <= stat_in;
      rd_word_ff <= word_ff[AW-1:0];
      rd_base_ff <= base_ff;
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[word_ff[AW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
   end

   assign rsp_result_block = res_blk_ff;
   assign rsp_bit_value    = bitv_ff;
   assign rsp_status       = stat_ff;
   assign rsp_free_count   = bba_pkg::FC_W'(free_ff);

endmodule

// ===== hw/rtl/bba_ctrl.sv =====
// Controller of the block bitmap allocator: sequences clear, scan and bit ops.
// Depends on bba_pkg; commands bba_dpath through cmd_type.
module bba_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic [bba_pkg::OP_W-1:0] req_op,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output bba_pkg::cmd_type         cmd,
   input  bba_pkg::status_type      stat
);

   localparam logic [2:0] S_RCLR  = 3'd0;
   localparam logic [2:0] S_IDLE  = 3'd1;
   localparam logic [2:0] S_SCAN  = 3'd2;
   localparam logic [2:0] S_WALK  = 3'd3;
   localparam logic [2:0] S_BITOP = 3'd4;
   localparam logic [2:0] S_ICLR  = 3'd5;
   localparam logic [2:0] S_RESP  = 3'd6;

   logic [2:0] state_ff, state_in;

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = (state_ff == S_RESP);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_RCLR: begin
            cmd.clear = 1'b1;
            if (stat.clr_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               case (req_op)
                  bba_pkg::OP_ALLOC: state_in = S_SCAN;
                  bba_pkg::OP_FREE, bba_pkg::OP_MARK, bba_pkg::OP_TEST: begin
                     state_in = stat.in_range ? S_WALK : S_RESP;
                  end
                  bba_pkg::OP_INIT:  state_in = S_ICLR;
                  default:           state_in = S_RESP;
               endcase
            end
         end
         S_SCAN: begin
            if (stat.chk_hit) begin
               cmd.alloc_hit = 1'b1;
               state_in      = S_RESP;
            end else if (stat.chk_miss || (!stat.chk_vld && !stat.issue_ok)) begin
               cmd.alloc_fail = 1'b1;
               state_in       = S_RESP;
            end else begin
               cmd.scan = 1'b1;
            end
         end
         S_WALK: begin
            cmd.walk = 1'b1;
            if (stat.walk_hit) begin
               state_in = S_BITOP;
            end
         end
         S_BITOP: begin
            cmd.bitop = 1'b1;
            state_in  = S_RESP;
         end
         S_ICLR: begin
            cmd.clear = 1'b1;
            if (stat.clr_last) begin
               state_in = S_RESP;
            end
         end
         S_RESP: begin
            if (rsp_ready) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_RCLR;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== hw/rtl/block_bitmap_allocator.sv =====
// Allocate scans the map one word read per cycle (pipelined) until a free bit or the store end;
// free, mark and test walk the word pointer to the block's word, then do one read-modify-write;
// initialise writes one map word per cycle; other ops and out-of-range go straight to the result.
// Throughput: one item at a time; the next beat is taken after the result beat leaves.
// Reset: registers load their reset values, then a clearing pass over all MAP_WORDS words
// zeroes the map with req_ready low; configuration writes are taken throughout.
module block_bitmap_allocator #(
   parameter int MAX_BLOCKS = 65536,
   parameter int WORD_BITS  = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [bba_pkg::OP_W-1:0]      req_op,
   input  logic [bba_pkg::BLK_W-1:0]     req_block_index,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [bba_pkg::BLK_W-1:0]     rsp_result_block,
   output logic                          rsp_bit_value,
   output logic [bba_pkg::STAT_W-1:0]    rsp_status,
   output logic [bba_pkg::FC_W-1:0]      rsp_free_count,
   input  logic                          csr_we,
   input  logic [bba_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [bba_pkg::CFG_W-1:0]     csr_wdata
);

   bba_pkg::cmd_type    cmd;
   bba_pkg::status_type stat;

   bba_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_op    (req_op),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd),
      .stat      (stat)
   );

   bba_dpath #(
      .MAX_BLOCKS (MAX_BLOCKS),
      .WORD_BITS  (WORD_BITS)
   ) u_dpath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .stat             (stat),
      .req_op           (req_op),
      .req_block_index  (req_block_index),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .rsp_result_block (rsp_result_block),
      .rsp_bit_value    (rsp_bit_value),
      .rsp_status       (rsp_status),
      .rsp_free_count   (rsp_free_count)
   );

`ifndef SYNTH
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid))
      else $error("input taken while a result beat is pending");

   a_long_ops_wait: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready &&
       (req_op == bba_pkg::OP_ALLOC || req_op == bba_pkg::OP_INIT)) |=> !rsp_valid)
      else $error("allocate or initialise answered without scanning");

   a_rsp_drops: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready) |=> (!rsp_valid && req_ready))
      else $error("result beat repeated or controller did not return to idle");
`endif

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps
// Regression bench for block_bitmap_allocator: directed and random map operations,
// each result beat checked against an in-bench model of the usage bitmap and free count.
// Depends on bba_pkg and the block_bitmap_allocator RTL only.
module tb_top;

   localparam int MAX_BLOCKS  = 65536;
   localparam int WORD_BITS   = 32;
   localparam int SCAN_CYCLES = MAX_BLOCKS / WORD_BITS + 8;
   localparam int CFG_MAX     = (1 << bba_pkg::CFG_W) - 1;

   localparam logic [bba_pkg::OP_W-1:0] OP_RSVD5 = 3'd5;
   localparam logic [bba_pkg::OP_W-1:0] OP_RSVD6 = 3'd6;
   localparam logic [bba_pkg::OP_W-1:0] OP_RSVD7 = 3'd7;

   typedef struct packed {
      logic [bba_pkg::BLK_W-1:0]  blk;
      logic                       bitv;
      logic [bba_pkg::STAT_W-1:0] status;
      logic [bba_pkg::FC_W-1:0]   free_cnt;
   } map_reply_type;

   logic                          clock           = 1'b0;
   logic                          reset           = 1'b1;
   logic                          req_valid       = 1'b0;
   logic                          req_ready;
   logic [bba_pkg::OP_W-1:0]      req_op          = bba_pkg::OP_ALLOC;
   logic [bba_pkg::BLK_W-1:0]     req_block_index = '0;
   logic                          rsp_valid;
   logic                          rsp_ready       = 1'b0;
   logic [bba_pkg::BLK_W-1:0]     rsp_result_block;
   logic                          rsp_bit_value;
   logic [bba_pkg::STAT_W-1:0]    rsp_status;
   logic [bba_pkg::FC_W-1:0]      rsp_free_count;
   logic                          csr_we          = 1'b0;
   logic [bba_pkg::CSR_IDX_W-1:0] csr_index       = bba_pkg::CSR_TOTAL;
   logic [bba_pkg::CFG_W-1:0]     csr_wdata       = '0;

   bit            used_map [MAX_BLOCKS];
   int unsigned   free_cnt_m  = MAX_BLOCKS;
   int unsigned   total_cfg   = bba_pkg::TOTAL_RST;
   int unsigned   resv_cfg    = bba_pkg::RESV_RST;
   map_reply_type predicted_replies[$];

   bit          steady        = 1'b0;
   int          mismatches    = 0;
   int          items_sent    = 0;
   int          beats_checked = 0;
   int          settings_used = 0;

   block_bitmap_allocator #(
      .MAX_BLOCKS(MAX_BLOCKS),
      .WORD_BITS (WORD_BITS)
   ) u_top (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_op          (req_op),
      .req_block_index (req_block_index),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_result_block(rsp_result_block),
      .rsp_bit_value   (rsp_bit_value),
      .rsp_status      (rsp_status),
      .rsp_free_count  (rsp_free_count),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic int unsigned store_size();
      return (total_cfg > MAX_BLOCKS) ? MAX_BLOCKS : total_cfg;
   endfunction

   function automatic map_reply_type apply_map_op(input logic [bba_pkg::OP_W-1:0] op,
                                                  input logic [bba_pkg::BLK_W-1:0] idx);
      map_reply_type r;
      int unsigned   size;
      int unsigned   resv;
      int unsigned   hit;
      size     = store_size();
      r.blk    = idx;
      r.bitv   = 1'b0;
      r.status = bba_pkg::ST_OK;
      case (op)
         bba_pkg::OP_ALLOC: begin
            r.blk = '0;
            hit = 0;
            while (hit < size && used_map[hit]) hit++;
            if (hit < size) begin
               used_map[hit] = 1'b1;
               r.blk = hit[bba_pkg::BLK_W-1:0];
               if (free_cnt_m > 0) free_cnt_m--;
            end else begin
               r.status = bba_pkg::ST_NOFREE;
            end
         end
         bba_pkg::OP_FREE, bba_pkg::OP_MARK, bba_pkg::OP_TEST: begin
            if (idx >= size) begin
               r.status = bba_pkg::ST_RANGE;
            end else begin
               r.bitv = used_map[idx];
               if (op == bba_pkg::OP_FREE) begin
                  if (!used_map[idx]) begin
                     r.status = bba_pkg::ST_DBLFREE;
                  end else begin
                     used_map[idx] = 1'b0;
                     if (free_cnt_m < size) free_cnt_m++;
                  end
               end else if (op == bba_pkg::OP_MARK && !used_map[idx]) begin
                  used_map[idx] = 1'b1;
                  if (free_cnt_m > 0) free_cnt_m--;
               end
            end
         end
         bba_pkg::OP_INIT: begin
            resv = (resv_cfg > size) ? size : resv_cfg;
            for (int b = 0; b < MAX_BLOCKS; b++) used_map[b] = (b < resv);
            free_cnt_m = size - resv;
            r.blk = '0;
         end
         default: ;
      endcase
      r.free_cnt = free_cnt_m[bba_pkg::FC_W-1:0];
      return r;
   endfunction

   function automatic logic [bba_pkg::OP_W-1:0] pick_op();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 40) return bba_pkg::OP_ALLOC;
      if (r < 62) return bba_pkg::OP_FREE;
      if (r < 72) return bba_pkg::OP_MARK;
      if (r < 86) return bba_pkg::OP_TEST;
      if (r < 91) return bba_pkg::OP_INIT;
      if (r < 94) return OP_RSVD5;
      if (r < 97) return OP_RSVD6;
      return OP_RSVD7;
   endfunction

   function automatic logic [bba_pkg::BLK_W-1:0] pick_index(input int unsigned size);
      if (size != 0 && $urandom_range(0, 4) != 0) begin
         return bba_pkg::BLK_W'($urandom_range(0, size - 1));
      end
      if ($urandom_range(0, 1) != 0) return bba_pkg::BLK_W'(size + $urandom_range(0, 3));
      return bba_pkg::BLK_W'($urandom);
   endfunction

   task automatic send_op(input logic [bba_pkg::OP_W-1:0] op,
                          input logic [bba_pkg::BLK_W-1:0] idx);
      int gap;
      gap = steady ? 0 : $urandom_range(0, 16);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_op          <= op;
      req_block_index <= idx;
      do @(posedge clock); while (req_ready !== 1'b1);
      predicted_replies.push_back(apply_map_op(op, idx));
      items_sent++;
   endtask

   // hold off requests until every outstanding beat has come back
   task automatic settle();
      req_valid <= 1'b0;
      while (predicted_replies.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic set_config(input int unsigned total, input int unsigned resv);
      settle();
      csr_we    <= 1'b1;
      csr_index <= bba_pkg::CSR_TOTAL;
      csr_wdata <= total[bba_pkg::CFG_W-1:0];
      @(posedge clock);
      csr_index <= bba_pkg::CSR_RESV;
      csr_wdata <= resv[bba_pkg::CFG_W-1:0];
      @(posedge clock);
      csr_we    <= 1'b0;
      total_cfg = total & CFG_MAX;
      resv_cfg  = resv & CFG_MAX;
      settings_used++;
   endtask

   task automatic test_reset_state();
      send_op(bba_pkg::OP_TEST, '0);
      send_op(bba_pkg::OP_ALLOC, 16'hFFFF);
      send_op(bba_pkg::OP_TEST, '0);
      send_op(bba_pkg::OP_FREE, '0);
      send_op(bba_pkg::OP_FREE, '0);
      send_op(bba_pkg::OP_MARK, 16'hFFFF);
      send_op(bba_pkg::OP_MARK, 16'hFFFF);
      send_op(bba_pkg::OP_TEST, 16'hFFFF);
      send_op(bba_pkg::OP_FREE, 16'hFFFF);
      send_op(OP_RSVD5, 16'hFFFF);
      send_op(OP_RSVD7, '0);
   endtask

   task automatic test_tiny_store();
      set_config(5, 2);
      send_op(bba_pkg::OP_INIT, 16'h00FF);
      repeat (4) send_op(bba_pkg::OP_ALLOC, '0);
      send_op(bba_pkg::OP_FREE, 16'd1);
      send_op(bba_pkg::OP_FREE, 16'd1);
      send_op(bba_pkg::OP_TEST, 16'd5);
   endtask

   task automatic test_size_extremes();
      set_config(0, 0);
      send_op(bba_pkg::OP_INIT, '0);
      send_op(bba_pkg::OP_ALLOC, '0);
      send_op(bba_pkg::OP_MARK, '0);
      set_config(1, CFG_MAX);
      send_op(bba_pkg::OP_INIT, '0);
      send_op(bba_pkg::OP_ALLOC, '0);
      set_config(CFG_MAX, MAX_BLOCKS);
      send_op(bba_pkg::OP_INIT, '0);
      send_op(bba_pkg::OP_FREE, 16'hFFFF);
   endtask

   task automatic test_random_small();
      int unsigned total;
      int unsigned resv;
      for (int phase = 0; phase < 4; phase++) begin
         total = $urandom_range(1, 96);
         resv  = $urandom_range(0, total + 4);
         set_config(total, resv);
         steady = (phase == 2);
         send_op(bba_pkg::OP_INIT, bba_pkg::BLK_W'($urandom));
         repeat (44) send_op(pick_op(), pick_index(total));
      end
      steady = 1'b0;
   endtask

   task automatic test_random_full();
      logic [bba_pkg::BLK_W-1:0] idx;
      set_config(MAX_BLOCKS, $urandom_range(0, 64));
      send_op(bba_pkg::OP_INIT, '0);
      repeat (40) send_op(pick_op(), bba_pkg::BLK_W'($urandom));
      // nearly full store: allocations scan to the top of the map
      set_config($urandom_range(MAX_BLOCKS + 1, CFG_MAX),
                 $urandom_range(MAX_BLOCKS - 100, MAX_BLOCKS - 1));
      send_op(bba_pkg::OP_INIT, bba_pkg::BLK_W'($urandom));
      repeat (40) begin
         idx = ($urandom_range(0, 1) != 0)
               ? bba_pkg::BLK_W'($urandom)
               : bba_pkg::BLK_W'($urandom_range(MAX_BLOCKS - 128, MAX_BLOCKS - 1));
         send_op(pick_op(), idx);
      end
   endtask

   initial begin : result_monitor
      map_reply_type want;
      int            stall;
      do @(posedge clock); while (reset);
      forever begin
         stall = steady ? 0 : $urandom_range(0, 16);
         if (stall != 0) begin
            rsp_ready <= 1'b0;
            do @(posedge clock); while (rsp_valid !== 1'b1);
            repeat (stall - 1) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (rsp_valid !== 1'b1);
         if (predicted_replies.size() == 0) begin
            $error("result beat with nothing outstanding: result_block %0d", rsp_result_block);
            mismatches++;
         end else begin
            want = predicted_replies.pop_front();
            beats_checked++;
            if (rsp_result_block !== want.blk) begin
               $error("result_block: expected %0d, got %0d", want.blk, rsp_result_block);
               mismatches++;
            end
            if (rsp_bit_value !== want.bitv) begin
               $error("bit_value: expected %0d, got %0d", want.bitv, rsp_bit_value);
               mismatches++;
            end
            if (rsp_status !== want.status) begin
               $error("status: expected %0d, got %0d", want.status, rsp_status);
               mismatches++;
            end
            if (rsp_free_count !== want.free_cnt) begin
               $error("free_count: expected %0d, got %0d", want.free_cnt, rsp_free_count);
               mismatches++;
            end
         end
      end
   end

   initial begin : watchdog
      #40_000_000;
      $display("block_bitmap_allocator regression: fail");
      $finish;
   end

   initial begin : sequencer
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      test_reset_state();
      test_tiny_store();
      test_size_extremes();
      test_random_small();
      test_random_full();
      settle();
      repeat (SCAN_CYCLES) @(posedge clock);
      $display("%0d map operations over %0d store settings, %0d result beats compared",
               items_sent, settings_used, beats_checked);
      if (mismatches == 0) begin
         $display("block_bitmap_allocator regression: pass");
      end else begin
         $display("block_bitmap_allocator regression: fail");
      end
      $finish;
   end

endmodule
